/* hdl/lzsswd_pkg.sv */
`timescale 1ns / 1ps
package lzsswd_pkg;

  // Default history depth; a power of two from 2048 to 4096.
  localparam int unsigned WINDOW_DEPTH_DEF = 2048;

  // Write position at the start of every job.
  localparam logic [11:0] WPOS_START = 12'h7EE;

  // Marker bit above a freshly loaded flag byte.
  localparam logic [8:0] FLAG_MARK = 9'h100;

  // Shortest match length.
  localparam logic [4:0] MATCH_LEN_BASE = 5'd3;

endpackage

/* hdl/lzsswd_hist.sv */
`timescale 1ns / 1ps
module lzsswd_hist #(
  parameter int unsigned DEPTH = lzsswd_pkg::WINDOW_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata,
  output logic          busy
);
  import lzsswd_pkg::*;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic          busy_r;
  logic [AW-1:0] clr_addr_r;

  // Zero the whole ring once after reset, one entry per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

/* hdl/lzss_window_decoder.sv */
`timescale 1ns / 1ps
// LZSS stream decoder with a WINDOW_DEPTH-byte history ring. Write output_size
// (address 0) to start a job, then stream compressed bytes in; in_tlast marks
// the last byte available. A flag byte or the first byte of a match gives no
// transfer (unless in_tlast ends the job early), a literal gives one result,
// and a match of length L (3 to 18) gives up to L results: the single history
// port reads one byte, then the copy unit emits and writes it back, byte by byte.
// Input is not taken until a literal or match is fully put out, and a stall
// on the output channel holds the output step. After reset the ring is zeroed
// entry by entry, and no input is taken meanwhile. Each result carries the
// byte (if any), completion and error flags and the compressed byte count.
module lzss_window_decoder #(
  parameter int unsigned WINDOW_DEPTH = lzsswd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] code_byte
  input  logic        in_tlast,     // source_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [7:0] data_byte, [39:8] bytes_consumed
  output logic [2:0]  out_tuser,    // [0] byte_valid, [1] job_done, [2] source_error
  output logic        out_tlast,    // run_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lzsswd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] WPOS_INIT = AW'(WPOS_START);

  typedef enum logic [1:0] {ST_IDLE, ST_PUT, ST_RD, ST_COPY} state_t;
  typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_MATCH} phase_t;

  typedef struct packed {
    logic err;
    logic done;
    logic last;
    logic valid;
  } res_flags_t;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt, phase_adv;
  logic [8:0] flag_r, flag_nxt, flag_adv;
  logic [7:0] match_low_r, match_low_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] produced_r, produced_nxt, prod_inc;
  logic [31:0] consumed_r, consumed_nxt;
  logic        finished_r, finished_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] off_r, off_nxt;
  logic [4:0]  len_r, len_nxt;
  logic        src_end_r, src_end_nxt;
  logic [7:0]  pend_data_r, pend_data_nxt;
  res_flags_t  pend_flags_r, pend_flags_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [31:0] out_cnt_r, out_cnt_nxt;
  res_flags_t  out_flags_r, out_flags_nxt;

  logic        slot_free, in_acc, cfg_wr, hit, out_load, last_byte;
  logic        mem_we, mem_re, hist_busy;
  logic [7:0]  mem_wd, mem_rd;
  logic [11:0] off_full;

  lzsswd_hist #(.DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (off_r),
    .rdata (mem_rd),
    .busy  (hist_busy)
  );

  assign in_tready  = (state_r == ST_IDLE) && !hist_busy;
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : size_r;

  assign prod_inc  = produced_r + 32'd1;
  assign hit       = (prod_inc == size_r);
  assign flag_adv  = flag_r >> 1;
  assign phase_adv = (flag_adv <= 9'd1) ? PH_FLAG : PH_TOKEN;
  assign off_full  = {in_tdata[7:4], match_low_r};
  assign last_byte = (len_r == 5'd1) || hit;
  assign mem_wd    = (state_r == ST_COPY) ? mem_rd : in_tdata;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    flag_nxt       = flag_r;
    match_low_nxt  = match_low_r;
    size_nxt       = size_r;
    produced_nxt   = produced_r;
    consumed_nxt   = consumed_r;
    finished_nxt   = finished_r;
    wp_nxt         = wp_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    src_end_nxt    = src_end_r;
    pend_data_nxt  = pend_data_r;
    pend_flags_nxt = pend_flags_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_cnt_nxt    = out_cnt_r;
    out_flags_nxt  = out_flags_r;
    out_load       = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && !finished_r) begin
          if (produced_r == size_r) begin
            // empty job: report completion; the accepted byte is not counted as consumed
            pend_data_nxt  = 8'd0;
            pend_flags_nxt = '{err: 1'b0, done: 1'b1, last: 1'b1, valid: 1'b0};
            finished_nxt   = 1'b1;
            state_nxt      = ST_PUT;
          end else begin
            consumed_nxt = consumed_r + 32'd1;
            case (phase_r)
              PH_TOKEN: begin
                if (flag_r[0]) begin
                  pend_data_nxt  = in_tdata;
                  pend_flags_nxt = '{err: in_tlast && !hit, done: hit, last: 1'b1,
                                     valid: 1'b1};
                  produced_nxt   = prod_inc;
                  if (hit || in_tlast) begin
                    finished_nxt = 1'b1;
                  end
                  if (!hit) begin
                    mem_we    = 1'b1;
                    wp_nxt    = wp_r + 1'b1;
                    flag_nxt  = flag_adv;
                    phase_nxt = phase_adv;
                  end
                  state_nxt = ST_PUT;
                end else begin
                  match_low_nxt = in_tdata;
                  phase_nxt     = PH_MATCH;
                  if (in_tlast) begin
                    pend_data_nxt  = 8'd0;
                    pend_flags_nxt = '{err: 1'b1, done: 1'b0, last: 1'b1, valid: 1'b0};
                    finished_nxt   = 1'b1;
                    state_nxt      = ST_PUT;
                  end
                end
              end
              PH_MATCH: begin
                off_nxt     = AW'(off_full);
                len_nxt     = {1'b0, in_tdata[3:0]} + MATCH_LEN_BASE;
                src_end_nxt = in_tlast;
                state_nxt   = ST_RD;
              end
              default: begin
                flag_nxt  = FLAG_MARK | {1'b0, in_tdata};
                phase_nxt = PH_TOKEN;
                if (in_tlast) begin
                  pend_data_nxt  = 8'd0;
                  pend_flags_nxt = '{err: 1'b1, done: 1'b0, last: 1'b1, valid: 1'b0};
                  finished_nxt   = 1'b1;
                  state_nxt      = ST_PUT;
                end
              end
            endcase
          end
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_data_nxt  = pend_data_r;
          out_flags_nxt = pend_flags_r;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_COPY;
      end
      ST_COPY: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_data_nxt  = mem_rd;
          out_flags_nxt = '{err: last_byte && !hit && src_end_r, done: hit,
                            last: last_byte, valid: 1'b1};
          produced_nxt  = prod_inc;
          off_nxt       = off_r + 1'b1;
          len_nxt       = len_r - 5'd1;
          // the byte that completes the job is not written back
          if (!hit) begin
            mem_we = 1'b1;
            wp_nxt = wp_r + 1'b1;
          end
          if (hit || (last_byte && src_end_r)) begin
            finished_nxt = 1'b1;
          end
          if (last_byte) begin
            if (!hit) begin
              flag_nxt  = flag_adv;
              phase_nxt = phase_adv;
            end
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_cnt_nxt   = consumed_r;
    end

    // a size write restarts the job; history is kept
    if (cfg_wr) begin
      size_nxt     = cfg_pwdata;
      wp_nxt       = WPOS_INIT;
      flag_nxt     = '0;
      phase_nxt    = PH_FLAG;
      produced_nxt = '0;
      consumed_nxt = '0;
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FLAG;
      flag_r      <= '0;
      size_r      <= '0;
      produced_r  <= '0;
      consumed_r  <= '0;
      finished_r  <= 1'b0;
      wp_r        <= WPOS_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      flag_r      <= flag_nxt;
      size_r      <= size_nxt;
      produced_r  <= produced_nxt;
      consumed_r  <= consumed_nxt;
      finished_r  <= finished_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    match_low_r  <= match_low_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    src_end_r    <= src_end_nxt;
    pend_data_r  <= pend_data_nxt;
    pend_flags_r <= pend_flags_nxt;
    out_data_r   <= out_data_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_flags_r  <= out_flags_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_data_r};
  assign out_tuser  = {out_flags_r.err, out_flags_r.done, out_flags_r.valid};
  assign out_tlast  = out_flags_r.last;

  a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_flags_nxt.done && !cfg_wr) |=> finished_r)
    else $error("job completion did not mark the job finished");

  a_copy_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (len_r != 5'd0))
    else $error("history read issued with no match bytes left");

  a_copy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> ($past(state_r) == ST_RD || $past(state_r) == ST_COPY))
    else $error("copy step entered without a history read");

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    hist_busy |-> !in_tready)
    else $error("input taken while history is being cleared");

endmodule
